[hw/rtl/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation core.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  // Port widths of the item fields
  localparam int DATA_W     = 32;
  localparam int EXP_PORT_W = 64;

  // Parameter defaults
  localparam int MOD_WIDTH_DEF = 32;
  localparam int EXP_WIDTH_DEF = 64;

  typedef logic [DATA_W-1:0] data_t;

  // Operand selection for the serial modular multiplier
  typedef enum logic [1:0] {
    OP_REDUCE,  // 1 * base mod m
    OP_MULRES,  // square * result mod m
    OP_SQUARE   // square * square mod m
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT_RED,
    ST_BIT,
    ST_WAIT_MUL,
    ST_WAIT_SQR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_res;
    logic start;
    op_t  op;
    logic wr_res;
    logic wr_sq;
    logic shift_e;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic e_zero;
    logic e_lsb;
    logic m_zero;
    logic mul_busy;
    logic mul_done;
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/mexp_mulmod.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] opa,     // multiplicand, must be <= m
  input  wire logic [WIDTH-1:0] opb,     // multiplier bits, any value
  input  wire logic [WIDTH-1:0] m,       // held stable while busy
  output logic                  busy,
  output logic                  done,
  output logic [WIDTH-1:0]      result
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] a_q;
  logic [WIDTH-1:0] b_q;
  logic [CW-1:0]    cnt;

  logic [WIDTH:0]   m_ext;
  logic [WIDTH:0]   dbl;
  logic [WIDTH:0]   red1;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   red2;

  // acc = (2*acc + bit*a) mod m, each half needs at most one subtract
  always_comb begin
    m_ext = {1'b0, m};
    dbl   = {acc, 1'b0};
    red1  = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum   = red1 + (b_q[WIDTH-1] ? {1'b0, a_q} : '0);
    red2  = (sum >= m_ext) ? (sum - m_ext) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_q <= opa;
      b_q <= opb;
    end else if (busy) begin
      acc <= red2[WIDTH-1:0];
      b_q <= b_q << 1;
    end
  end

  assign result = acc;

  // a finished product is always fully reduced
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> (acc < m))
    else $error("mulmod result not below modulus");

endmodule

`default_nettype wire

[hw/rtl/mexp_datapath.sv]
// Datapath: operand registers, exponent shifter, multiplier and result register.
`timescale 1ns / 1ps
`default_nettype none

module mexp_datapath #(
  parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mexp_pkg::ctrl_cmd_t               cmd,
  output mexp_pkg::dp_status_t                   sts,
  input  wire logic [mexp_pkg::DATA_W-1:0]       base_value,
  input  wire logic [mexp_pkg::EXP_PORT_W-1:0]   exponent,
  input  wire logic [mexp_pkg::DATA_W-1:0]       modulus,
  output logic [mexp_pkg::DATA_W-1:0]            power_result
);

  localparam int DW = (MOD_WIDTH < mexp_pkg::DATA_W) ? MOD_WIDTH : mexp_pkg::DATA_W;

  typedef logic [DW-1:0]        dword_t;
  typedef logic [EXP_WIDTH-1:0] eword_t;

  dword_t m_q;
  dword_t sq;
  dword_t res;
  dword_t out_data;
  eword_t e_q;

  dword_t opa;
  dword_t opb;
  dword_t mul_result;
  logic   mul_busy;
  logic   mul_done;

  always_comb begin
    case (cmd.op)
      mexp_pkg::OP_REDUCE: begin
        opa = dword_t'(1);
        opb = sq;
      end
      mexp_pkg::OP_MULRES: begin
        opa = sq;
        opb = res;
      end
      mexp_pkg::OP_SQUARE: begin
        opa = sq;
        opb = sq;
      end
      default: begin
        opa = sq;
        opb = sq;
      end
    endcase
  end

  mexp_mulmod #(
    .WIDTH (DW)
  ) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.start),
    .opa    (opa),
    .opb    (opb),
    .m      (m_q),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_result)
  );

  // sq first holds the raw base, then the running square
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_q <= dword_t'(modulus);
      sq  <= dword_t'(base_value);
      e_q <= eword_t'(exponent);
      res <= dword_t'(1);
    end else begin
      if (cmd.clr_res) res <= '0;
      if (cmd.wr_res)  res <= mul_result;
      if (cmd.wr_sq)   sq  <= mul_result;
      if (cmd.shift_e) e_q <= e_q >> 1;
    end
    if (cmd.out_load) out_data <= res;
  end

  always_comb begin
    sts.e_zero   = (e_q == '0);
    sts.e_lsb    = e_q[0];
    sts.m_zero   = (m_q == '0);
    sts.mul_busy = mul_busy;
    sts.mul_done = mul_done;
  end

  assign power_result = mexp_pkg::data_t'(out_data);

endmodule

`default_nettype wire

[hw/rtl/mexp_ctrl.sv]
// Controller state machine: sequences reduction, multiplies and output.
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire mexp_pkg::dp_status_t  sts,
  output mexp_pkg::ctrl_cmd_t        cmd
);

  mexp_pkg::state_t state;
  mexp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = mexp_pkg::ctrl_cmd_t'('0);
    cmd.op     = mexp_pkg::OP_REDUCE;
    case (state)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_CHECK: begin
        // zero exponent keeps the preset 1; zero modulus answers 0
        if (sts.e_zero) begin
          state_next = mexp_pkg::ST_FINISH;
        end else if (sts.m_zero) begin
          cmd.clr_res = 1'b1;
          state_next  = mexp_pkg::ST_FINISH;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = mexp_pkg::OP_REDUCE;
          state_next = mexp_pkg::ST_WAIT_RED;
        end
      end
      mexp_pkg::ST_WAIT_RED: begin
        if (sts.mul_done) begin
          cmd.wr_sq  = 1'b1;
          state_next = mexp_pkg::ST_BIT;
        end
      end
      mexp_pkg::ST_BIT: begin
        // stop as soon as no set exponent bits remain
        if (sts.e_zero) begin
          state_next = mexp_pkg::ST_FINISH;
        end else if (sts.e_lsb) begin
          cmd.start  = 1'b1;
          cmd.op     = mexp_pkg::OP_MULRES;
          state_next = mexp_pkg::ST_WAIT_MUL;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = mexp_pkg::OP_SQUARE;
          state_next = mexp_pkg::ST_WAIT_SQR;
        end
      end
      mexp_pkg::ST_WAIT_MUL: begin
        if (sts.mul_done) begin
          cmd.wr_res = 1'b1;
          cmd.start  = 1'b1;
          cmd.op     = mexp_pkg::OP_SQUARE;
          state_next = mexp_pkg::ST_WAIT_SQR;
        end
      end
      mexp_pkg::ST_WAIT_SQR: begin
        if (sts.mul_done) begin
          cmd.wr_sq   = 1'b1;
          cmd.shift_e = 1'b1;
          state_next  = mexp_pkg::ST_BIT;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state == mexp_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !sts.mul_busy)
    else $error("multiplier started while busy");

  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> (state == mexp_pkg::ST_WAIT_RED || state == mexp_pkg::ST_WAIT_MUL ||
                      state == mexp_pkg::ST_WAIT_SQR))
    else $error("multiplier finished outside a wait state");

  a_bit_starts: assert property (@(posedge clk) disable iff (rst)
    (state == mexp_pkg::ST_BIT && !sts.e_zero) |=> sts.mul_busy)
    else $error("exponent bit step did not start the multiplier");

endmodule

`default_nettype wire

[hw/rtl/modular_exponentiation_core.sv]
// Top level of the modular exponentiation core.
`timescale 1ns / 1ps
`default_nettype none

// Computes base_value ** exponent mod modulus with right-to-left binary
// square-and-multiply. One item is worked on at a time; in_ready is high
// only while the core is idle, but a finished result waits in its own
// output register, so the next item can be taken while out_valid is held.
// All arithmetic runs through one shared bit-serial modular multiplier that
// retires one multiplier bit per cycle (DW = min(MOD_WIDTH, 32) is its
// operand width). An item first reduces the base, then for each exponent
// bit up to the highest set one squares, and multiplies into the result
// first when the bit is set. An exponent of zero, or a zero modulus, skips
// the multiplier and goes straight to the output. Only the low EXP_WIDTH
// exponent bits and the low DW bits of base and modulus are used. A zero
// exponent yields 1 for any modulus; a zero modulus with a nonzero
// exponent yields 0.
module modular_exponentiation_core #(
  parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mexp_pkg::DATA_W-1:0]      base_value,
  input  wire logic [mexp_pkg::EXP_PORT_W-1:0]  exponent,
  input  wire logic [mexp_pkg::DATA_W-1:0]      modulus,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [mexp_pkg::DATA_W-1:0]           power_result
);

  mexp_pkg::ctrl_cmd_t  cmd;
  mexp_pkg::dp_status_t sts;

  // sequencing: load, reduce base, then per-bit multiply/square
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // operand registers, shared multiplier, output item register
  mexp_datapath #(
    .MOD_WIDTH (MOD_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .base_value   (base_value),
    .exponent     (exponent),
    .modulus      (modulus),
    .power_result (power_result)
  );

endmodule

`default_nettype wire
